// File: rtl/double_ended_queue_top_assert.svh
// Assertion macros used by the double-ended queue top.
`ifndef DOUBLE_ENDED_QUEUE_TOP_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define DQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define DQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/dq_pkg.sv
// Package with the types and constants of the double-ended queue.
package dq_pkg;

  // Default number of entries.
  localparam int unsigned DEPTH_DEF = 16;

  // Fixed field widths.
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned OP_W     = 2;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 5;

  // Operation codes.
  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_PUSH_BACK  = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_POP_BACK   = 2'd3
  } op_t;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Command broadcast to every cell; at most one bit is set.
  typedef struct packed {
    logic push_front;
    logic push_back;
    logic pop_front;
    logic pop_back;
  } cell_cmd_t;

endpackage

// File: rtl/double_ended_queue_top.sv
// One word in flight: a new word is taken only once the result of the last one is formed
// and the output register is free or being read; the cell row updates in the accept
// cycle and the result register is formed from the row in the next cycle.
// Reset clears the cell valid bits, the count and the handshake state;
// stored values are not reset and are never read before they are written.
module double_ended_queue_top #(
  parameter int unsigned DEPTH = dq_pkg::DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [dq_pkg::OP_W-1:0]            in_opcode,
  input  logic signed [dq_pkg::DATA_W-1:0]   in_push_value,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [dq_pkg::STATUS_W-1:0]        out_status,
  output logic signed [dq_pkg::DATA_W-1:0]   out_popped_value,
  output logic                               out_is_empty,
  output logic                               out_is_full,
  output logic [dq_pkg::COUNT_W-1:0]         out_entry_count,
  output logic signed [dq_pkg::DATA_W-1:0]   out_front_value,
  output logic signed [dq_pkg::DATA_W-1:0]   out_back_value
);

  `include "double_ended_queue_top_assert.svh"

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic                             accept;
  logic                             is_full_now;
  logic                             is_empty_now;
  dq_pkg::cell_cmd_t                cmd;
  dq_pkg::status_t                  status_nxt;
  logic signed [dq_pkg::DATA_W-1:0] popped_nxt;
  logic [CntW-1:0]                  count_r;
  logic [CntW-1:0]                  count_nxt;
  logic                             pend_r;
  dq_pkg::status_t                  stat_r;
  logic signed [dq_pkg::DATA_W-1:0] popped_r;
  logic                             out_valid_r;
  logic                             out_valid_nxt;
  logic [CntW+dq_pkg::COUNT_W-1:0]  count_ext;

  logic                             valid_w [DEPTH];
  logic signed [dq_pkg::DATA_W-1:0] value_w [DEPTH];
  logic signed [dq_pkg::DATA_W-1:0] tail_w  [DEPTH+1];
  logic [DEPTH-1:0]                 valid_vec;

  // Input handshake: one word in flight, output register free by the time it is formed.
  assign in_ready     = !pend_r && (!out_valid_r || out_ready);
  assign accept       = in_valid && in_ready;
  assign is_full_now  = (count_r == CntW'(DEPTH));
  assign is_empty_now = (count_r == '0);

  // Decode the operation against the current fill level.
  always_comb begin
    cmd        = '0;
    status_nxt = dq_pkg::ST_OK;
    popped_nxt = '0;
    count_nxt  = count_r;
    case (dq_pkg::op_t'(in_opcode))
      dq_pkg::OP_PUSH_FRONT: begin
        if (is_full_now) begin
          status_nxt = dq_pkg::ST_FULL;
        end else begin
          cmd.push_front = accept;
          count_nxt      = count_r + 1'b1;
        end
      end
      dq_pkg::OP_PUSH_BACK: begin
        if (is_full_now) begin
          status_nxt = dq_pkg::ST_FULL;
        end else begin
          cmd.push_back = accept;
          count_nxt     = count_r + 1'b1;
        end
      end
      dq_pkg::OP_POP_FRONT: begin
        if (is_empty_now) begin
          status_nxt = dq_pkg::ST_EMPTY;
        end else begin
          cmd.pop_front = accept;
          popped_nxt    = value_w[0];
          count_nxt     = count_r - 1'b1;
        end
      end
      dq_pkg::OP_POP_BACK: begin
        if (is_empty_now) begin
          status_nxt = dq_pkg::ST_EMPTY;
        end else begin
          cmd.pop_back = accept;
          popped_nxt   = tail_w[0];
          count_nxt    = count_r - 1'b1;
        end
      end
      default: begin
        status_nxt = dq_pkg::ST_OK;
      end
    endcase
  end

  // The row of cells; cell zero holds the front word.
  assign tail_w[DEPTH] = '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                             prev_valid;
    logic signed [dq_pkg::DATA_W-1:0] prev_value;
    logic                             next_valid;
    logic signed [dq_pkg::DATA_W-1:0] next_value;

    if (i == 0) begin : g_first
      assign prev_valid = 1'b1;
      assign prev_value = in_push_value;
    end else begin : g_mid
      assign prev_valid = valid_w[i-1];
      assign prev_value = value_w[i-1];
    end

    if (i == DEPTH - 1) begin : g_end
      assign next_valid = 1'b0;
      assign next_value = '0;
    end else begin : g_inner
      assign next_valid = valid_w[i+1];
      assign next_value = value_w[i+1];
    end

    dq_cell u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .cmd_i        (cmd),
      .push_value_i (in_push_value),
      .prev_valid_i (prev_valid),
      .prev_value_i (prev_value),
      .next_valid_i (next_valid),
      .next_value_i (next_value),
      .tail_i       (tail_w[i+1]),
      .valid_o      (valid_w[i]),
      .value_o      (value_w[i]),
      .tail_o       (tail_w[i])
    );

    assign valid_vec[i] = valid_w[i];
  end

  // Control registers.
  assign out_valid_nxt = pend_r ? 1'b1 : (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r <= count_nxt;
      end
      pend_r      <= accept;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Per-word results held until the row has settled.
  always_ff @(posedge clk) begin
    if (accept) begin
      stat_r   <= status_nxt;
      popped_r <= popped_nxt;
    end
  end

  // Output register, formed from the updated row.
  assign count_ext = {{dq_pkg::COUNT_W{1'b0}}, count_r};

  always_ff @(posedge clk) begin
    if (pend_r) begin
      out_status       <= stat_r;
      out_popped_value <= popped_r;
      out_is_empty     <= is_empty_now;
      out_is_full      <= is_full_now;
      out_entry_count  <= count_ext[dq_pkg::COUNT_W-1:0];
      out_front_value  <= valid_w[0] ? value_w[0] : '0;
      out_back_value   <= tail_w[0];
    end
  end

  assign out_valid = out_valid_r;

  // Assertions.
  `DQ_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CntW'(DEPTH), "count exceeds depth")
  `DQ_ASSERT_NOW(a_valid_count, 1'b1, $countones(valid_vec) == count_r,
                 "valid cells disagree with count")
  `DQ_ASSERT_NEXT(a_accept_pend, accept, pend_r && !in_ready, "accept did not start work")
  `DQ_ASSERT_NEXT(a_pend_out, pend_r, out_valid_r, "result not presented after work")
  `DQ_ASSERT_NOW(a_full_status, out_valid_r && out_status == dq_pkg::ST_FULL, out_is_full,
                 "full status without full flag")

endmodule

// File: rtl/dq_cell.sv
// One storage cell of the double-ended queue chain.
module dq_cell (
  input  logic                           clk,
  input  logic                           rst_n,
  input  dq_pkg::cell_cmd_t              cmd_i,
  input  logic signed [dq_pkg::DATA_W-1:0] push_value_i,
  input  logic                           prev_valid_i,
  input  logic signed [dq_pkg::DATA_W-1:0] prev_value_i,
  input  logic                           next_valid_i,
  input  logic signed [dq_pkg::DATA_W-1:0] next_value_i,
  input  logic signed [dq_pkg::DATA_W-1:0] tail_i,
  output logic                           valid_o,
  output logic signed [dq_pkg::DATA_W-1:0] value_o,
  output logic signed [dq_pkg::DATA_W-1:0] tail_o
);

  logic                           valid_r;
  logic                           valid_nxt;
  logic signed [dq_pkg::DATA_W-1:0] value_r;
  logic signed [dq_pkg::DATA_W-1:0] value_nxt;
  logic                           is_last;
  logic                           is_first_free;

  // The queue occupies a contiguous run of cells starting at cell zero.
  assign is_last       = valid_r && !next_valid_i;
  assign is_first_free = !valid_r && prev_valid_i;

  // Front operations shift the whole row; back operations touch only the end cell.
  always_comb begin
    valid_nxt = valid_r;
    value_nxt = value_r;
    if (cmd_i.push_front) begin
      valid_nxt = prev_valid_i;
      value_nxt = prev_value_i;
    end else if (cmd_i.push_back) begin
      if (is_first_free) begin
        valid_nxt = 1'b1;
        value_nxt = push_value_i;
      end
    end else if (cmd_i.pop_front) begin
      valid_nxt = next_valid_i;
      value_nxt = next_value_i;
    end else if (cmd_i.pop_back) begin
      if (is_last) begin
        valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  // The last occupied cell drives its word onto the back-value chain.
  assign tail_o  = tail_i | (is_last ? value_r : '0);
  assign valid_o = valid_r;
  assign value_o = value_r;

endmodule

// File: sim/double_ended_queue_checker.sv
// Checker that predicts and compares every result word of the double-ended queue.
`timescale 1ns / 1ps

module double_ended_queue_checker #(
  parameter int unsigned DEPTH = dq_pkg::DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  input  logic                               in_ready,
  input  logic [dq_pkg::OP_W-1:0]            in_opcode,
  input  logic signed [dq_pkg::DATA_W-1:0]   in_push_value,
  input  logic                               out_valid,
  input  logic                               out_ready,
  input  logic [dq_pkg::STATUS_W-1:0]        out_status,
  input  logic signed [dq_pkg::DATA_W-1:0]   out_popped_value,
  input  logic                               out_is_empty,
  input  logic                               out_is_full,
  input  logic [dq_pkg::COUNT_W-1:0]         out_entry_count,
  input  logic signed [dq_pkg::DATA_W-1:0]   out_front_value,
  input  logic signed [dq_pkg::DATA_W-1:0]   out_back_value,
  output int                                 mismatch_count,
  output int                                 awaited_count
);

  // One predicted result word.
  typedef struct {
    dq_pkg::status_t                   status;
    logic signed [dq_pkg::DATA_W-1:0]  popped;
    logic                              is_empty;
    logic                              is_full;
    logic [dq_pkg::COUNT_W-1:0]        count;
    logic signed [dq_pkg::DATA_W-1:0]  front;
    logic signed [dq_pkg::DATA_W-1:0]  back;
  } deque_result_t;

  // Shadow model of the queue as a ring buffer, and the words still owed by the block.
  logic signed [dq_pkg::DATA_W-1:0] slots [DEPTH];
  int unsigned                      head;
  int unsigned                      held;
  deque_result_t                    awaited [$];

  initial begin
    mismatch_count = 0;
    awaited_count  = 0;
  end

  // Apply one operation to the shadow queue and record the word it must produce.
  task automatic predict_deque_op(input dq_pkg::op_t op,
                                  input logic signed [dq_pkg::DATA_W-1:0] value);
    deque_result_t r;
    r.status = dq_pkg::ST_OK;
    r.popped = '0;
    if (op == dq_pkg::OP_PUSH_FRONT || op == dq_pkg::OP_PUSH_BACK) begin
      if (held >= DEPTH) begin
        // A full queue drops the value and stays as it is.
        r.status = dq_pkg::ST_FULL;
      end else if (op == dq_pkg::OP_PUSH_FRONT) begin
        head = (head + DEPTH - 1) % DEPTH;
        slots[head] = value;
        held++;
      end else begin
        slots[(head + held) % DEPTH] = value;
        held++;
      end
    end else if (held == 0) begin
      r.status = dq_pkg::ST_EMPTY;
    end else if (op == dq_pkg::OP_POP_FRONT) begin
      r.popped = slots[head];
      head = (head + 1) % DEPTH;
      held--;
    end else begin
      r.popped = slots[(head + held - 1) % DEPTH];
      held--;
    end
    // Flags and peek values describe the queue after the operation.
    r.is_empty = (held == 0);
    r.is_full  = (held >= DEPTH);
    r.count    = held[dq_pkg::COUNT_W-1:0];
    r.front    = (held != 0) ? slots[head] : '0;
    r.back     = (held != 0) ? slots[(head + held - 1) % DEPTH] : '0;
    awaited.push_back(r);
  endtask

  // Compare one field, treating unknown bits as a mismatch.
  task automatic check_field(input string name, input logic [dq_pkg::DATA_W-1:0] want,
                             input logic [dq_pkg::DATA_W-1:0] got);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t ns: %s expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  // Watch both channels at each rising edge.
  always @(posedge clk) begin
    deque_result_t want;
    if (!rst_n) begin
      head = 0;
      held = 0;
      awaited.delete();
      awaited_count <= 0;
    end else begin
      if (in_valid && in_ready) begin
        predict_deque_op(dq_pkg::op_t'(in_opcode), in_push_value);
      end
      if (out_valid && out_ready) begin
        if (awaited.size() == 0) begin
          mismatch_count++;
          $display("%0t ns: result word expected none actual status %0h count %0h",
                   $time, out_status, out_entry_count);
        end else begin
          want = awaited.pop_front();
          check_field("status", want.status, out_status);
          check_field("popped_value", want.popped, out_popped_value);
          check_field("is_empty", want.is_empty, out_is_empty);
          check_field("is_full", want.is_full, out_is_full);
          check_field("entry_count", want.count, out_entry_count);
          check_field("front_value", want.front, out_front_value);
          check_field("back_value", want.back, out_back_value);
        end
      end
      awaited_count <= awaited.size();
    end
  end

endmodule

// File: sim/tb.sv
// Testbench top that drives the double-ended queue and reports the verdict.
`timescale 1ns / 1ps

module tb;

  localparam int unsigned DEPTH = dq_pkg::DEPTH_DEF;
  localparam int HOLD_CYCLES    = 200;
  localparam int RANDOM_BLOCKS  = 28;
  localparam int BLOCK_WORDS    = 25;
  localparam int BURST_WORDS    = 40;

  logic                              clk;
  logic                              rst_n;
  logic                              in_valid;
  logic                              in_ready;
  logic [dq_pkg::OP_W-1:0]           in_opcode;
  logic signed [dq_pkg::DATA_W-1:0]  in_push_value;
  logic                              out_valid;
  logic                              out_ready;
  logic [dq_pkg::STATUS_W-1:0]       out_status;
  logic signed [dq_pkg::DATA_W-1:0]  out_popped_value;
  logic                              out_is_empty;
  logic                              out_is_full;
  logic [dq_pkg::COUNT_W-1:0]        out_entry_count;
  logic signed [dq_pkg::DATA_W-1:0]  out_front_value;
  logic signed [dq_pkg::DATA_W-1:0]  out_back_value;
  int                                mismatch_count;
  int                                awaited_count;

  // Shared between the sender and the receiver.
  bit calm;
  bit hold_request;
  bit holding;

  double_ended_queue_top #(.DEPTH(DEPTH)) DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_opcode        (in_opcode),
    .in_push_value    (in_push_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_popped_value (out_popped_value),
    .out_is_empty     (out_is_empty),
    .out_is_full      (out_is_full),
    .out_entry_count  (out_entry_count),
    .out_front_value  (out_front_value),
    .out_back_value   (out_back_value)
  );

  double_ended_queue_checker #(.DEPTH(DEPTH)) result_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_opcode        (in_opcode),
    .in_push_value    (in_push_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_popped_value (out_popped_value),
    .out_is_empty     (out_is_empty),
    .out_is_full      (out_is_full),
    .out_entry_count  (out_entry_count),
    .out_front_value  (out_front_value),
    .out_back_value   (out_back_value),
    .mismatch_count   (mismatch_count),
    .awaited_count    (awaited_count)
  );

  // 12 ns clock.
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Corner values of a signed 32-bit word.
  function automatic logic signed [dq_pkg::DATA_W-1:0] corner_value(input int idx);
    case (idx)
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return -32'sd1;
      default: return '0;
    endcase
  endfunction

  // Mostly random values, with the corners showing up now and then.
  function automatic logic signed [dq_pkg::DATA_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 19);
    if (r < 4) return corner_value(r);
    return $urandom;
  endfunction

  // Push with the given percentage, otherwise pop; either end at random.
  function automatic dq_pkg::op_t pick_op(input int push_pct);
    if ($urandom_range(0, 99) < push_pct) begin
      return $urandom_range(0, 1) ? dq_pkg::OP_PUSH_BACK : dq_pkg::OP_PUSH_FRONT;
    end
    return $urandom_range(0, 1) ? dq_pkg::OP_POP_BACK : dq_pkg::OP_POP_FRONT;
  endfunction

  // Idle gap in cycles: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Offer one word after an idle gap and hold it until the block takes it.
  task automatic send_word(input dq_pkg::op_t op,
                           input logic signed [dq_pkg::DATA_W-1:0] value,
                           input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_opcode     <= op;
    in_push_value <= value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Stop sending until every predicted word has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (awaited_count == 0);
    @(posedge clk);
  endtask

  // Receiver: random ready pattern, plus a long hold-off on request.
  initial begin : receiver
    int run;
    int gap;
    out_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        holding      = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        holding = 1'b0;
      end
      out_ready <= 1'b1;
      run = calm ? 50 : $urandom_range(1, 20);
      repeat (run) @(posedge clk);
      gap = pick_gap();
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  // Sender: reset, directed words, random words, then the verdict.
  initial begin : sender
    int push_pct;
    calm          = 1'b0;
    hold_request  = 1'b0;
    holding       = 1'b0;
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_opcode     <= dq_pkg::OP_PUSH_FRONT;
    in_push_value <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Pops on an empty queue.
    send_word(dq_pkg::OP_POP_FRONT, pick_value(), pick_gap());
    send_word(dq_pkg::OP_POP_BACK, pick_value(), pick_gap());

    // Fill from both ends, corners first.
    for (int i = 0; i < DEPTH; i++) begin
      send_word(i[0] ? dq_pkg::OP_PUSH_BACK : dq_pkg::OP_PUSH_FRONT,
                (i < 4) ? corner_value(i) : pick_value(), pick_gap());
    end

    // Pushes on a full queue, then a pop from each end.
    send_word(dq_pkg::OP_PUSH_FRONT, pick_value(), pick_gap());
    send_word(dq_pkg::OP_PUSH_BACK, pick_value(), pick_gap());
    send_word(dq_pkg::OP_POP_FRONT, pick_value(), pick_gap());
    send_word(dq_pkg::OP_POP_BACK, pick_value(), pick_gap());
    wait_drained();

    // Random blocks, each leaning toward filling, draining or neither.
    for (int blk = 0; blk < RANDOM_BLOCKS; blk++) begin
      if (blk == 8) begin
        // Back-to-back words while the receiver holds off.
        in_valid <= 1'b0;
        hold_request = 1'b1;
        wait (holding);
        @(posedge clk);
        for (int k = 0; k < BURST_WORDS; k++) begin
          send_word(pick_op(60), pick_value(), 0);
        end
      end
      if (blk == 18) wait_drained();
      calm = ($urandom_range(0, 5) == 0);
      case ($urandom_range(0, 2))
        0:       push_pct = 85;
        1:       push_pct = 15;
        default: push_pct = 50;
      endcase
      for (int k = 0; k < BLOCK_WORDS; k++) begin
        send_word(pick_op(push_pct), pick_value(), pick_gap());
      end
    end

    // Let the last words come back, then a few quiet cycles.
    calm = 1'b0;
    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("double_ended_queue_top: match");
    end else begin
      $display("double_ended_queue_top: mismatch");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #6_000_000;
    $display("double_ended_queue_top: mismatch");
    $finish;
  end

endmodule

// File: double_ended_queue_top.f
+incdir+rtl
rtl/dq_pkg.sv
rtl/dq_cell.sv
rtl/double_ended_queue_top.sv
sim/double_ended_queue_checker.sv
sim/tb.sv
